[rtl/fau_pkg.sv]
// Shared types and codes for the fraction arithmetic unit.
package fau_pkg;

   // Operation codes carried by a request.
   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_SUB    = 3'd1;
   localparam logic [2:0] CMD_MUL    = 3'd2;
   localparam logic [2:0] CMD_DIV    = 3'd3;
   localparam logic [2:0] CMD_EQ     = 3'd4;
   localparam logic [2:0] CMD_LT     = 3'd5;
   localparam logic [2:0] CMD_GT     = 3'd6;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // Error codes returned with a result.
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_DEN  = 2'd1;
   localparam logic [1:0] ERR_DIV  = 2'd2;

   // How the result registers are loaded when a request finishes.
   typedef enum logic [2:0] {
      FIN_NONE    = 3'd0,
      FIN_ZERO    = 3'd1,
      FIN_ERR_DEN = 3'd2,
      FIN_ERR_DIV = 3'd3,
      FIN_CMP     = 3'd4,
      FIN_FRAC0   = 3'd5,
      FIN_FRAC    = 3'd6
   } fin_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    cap;
      logic    mul1;
      logic    mul2;
      logic    mul3;
      logic    comb;
      logic    gcd_load;
      logic    gcd_step;
      logic    div_load;
      logic    div_den;
      logic    div_step;
      fin_type fin;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic unused;
      logic bad_den;
      logic div_zero;
      logic is_cmp;
      logic num_zero;
      logic gcd_done;
      logic div_last;
   } sts_type;

endpackage

[rtl/fraction_arithmetic_unit.sv]
// Fraction arithmetic unit: one request at a time, reduced by binary gcd and division.
// A request ends in the check state for a zero denominator, division by zero or the
// unused command, and in the evaluate state for compares and zero results; otherwise
// its duration is set by the gcd loop and the two bit-serial divisions.
// A new request is taken only once the last has finished; the receiver cannot stall.
// Synchronous active-high reset returns the controller to idle with no strobe.
module fraction_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [15:0] req_a_num,
   input  logic signed [15:0] req_a_den,
   input  logic signed [15:0] req_b_num,
   input  logic signed [15:0] req_b_den,
   output logic               rsp_valid,
   output logic signed [32:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_cmp_true,
   output logic [1:0]         rsp_error
);
   import fau_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // Sequencer.
   fau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .sts       (sts)
   );

   // Arithmetic.
   fau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .ctl          (ctl),
      .sts          (sts),
      .req_cmd      (req_cmd),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_cmp_true (rsp_cmp_true),
      .rsp_error    (rsp_error)
   );

endmodule

[rtl/fau_datapath.sv]
// Datapath: operand registers, shared multiplier, binary gcd and restoring divider.
module fau_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                clock,
   input  fau_pkg::ctl_type    ctl,
   output fau_pkg::sts_type    sts,
   input  logic [2:0]          req_cmd,
   input  logic signed [15:0]  req_a_num,
   input  logic signed [15:0]  req_a_den,
   input  logic signed [15:0]  req_b_num,
   input  logic signed [15:0]  req_b_den,
   output logic signed [32:0]  rsp_res_num,
   output logic [30:0]         rsp_res_den,
   output logic                rsp_cmp_true,
   output logic [1:0]          rsp_error
);
   import fau_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int CW = $clog2(PW + 1);

   logic [31:0]   an_ext, ad_ext, bn_ext, bd_ext;
   logic [W-1:0]  an_raw, ad_raw, bn_raw, bd_raw;
   logic [2:0]    cmd_ff;
   logic          an_neg_ff, bn_neg_ff;
   logic [W-1:0]  an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] prod;
   logic [PW-1:0] p_ff, q_ff, d_ff;
   logic [PW-1:0] nm_ff, nm_in;
   logic          neg_ff, neg_in;
   logic          q_neg;
   logic [PW-1:0] gx_ff, gy_ff, gx_in, gy_in;
   logic [CW-1:0] gk_ff, gk_in;
   logic [PW-1:0] rem_ff, quo_ff, qnum_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW:0]   trial;
   logic          fits;
   logic [63:0]   num_wide, num_sgn, den_wide;
   logic          cmp_val;

   // Operands are the low OPERAND_WIDTH bits of each field.
   assign an_ext = 32'($unsigned(req_a_num));
   assign ad_ext = 32'($unsigned(req_a_den));
   assign bn_ext = 32'($unsigned(req_b_num));
   assign bd_ext = 32'($unsigned(req_b_den));
   assign an_raw = an_ext[W-1:0];
   assign ad_raw = ad_ext[W-1:0];
   assign bn_raw = bn_ext[W-1:0];
   assign bd_raw = bd_ext[W-1:0];

   // Capture magnitudes; each denominator's sign moves to its numerator.
   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         cmd_ff    <= req_cmd;
         an_mag_ff <= an_raw[W-1] ? (~an_raw + 1'b1) : an_raw;
         ad_mag_ff <= ad_raw[W-1] ? (~ad_raw + 1'b1) : ad_raw;
         bn_mag_ff <= bn_raw[W-1] ? (~bn_raw + 1'b1) : bn_raw;
         bd_mag_ff <= bd_raw[W-1] ? (~bd_raw + 1'b1) : bd_raw;
         an_neg_ff <= (an_raw[W-1] ^ ad_raw[W-1]) && (an_raw != '0);
         bn_neg_ff <= (bn_raw[W-1] ^ bd_raw[W-1]) && (bn_raw != '0);
      end
   end

   // One shared multiplier, one product per cycle.
   always_comb begin
      mul_a = ad_mag_ff;
      mul_b = (cmd_ff == CMD_DIV) ? bn_mag_ff : bd_mag_ff;
      if (ctl.mul1) begin
         mul_a = an_mag_ff;
         mul_b = (cmd_ff == CMD_MUL) ? bn_mag_ff : bd_mag_ff;
      end else if (ctl.mul2) begin
         mul_a = bn_mag_ff;
         mul_b = ad_mag_ff;
      end
   end

   assign prod = PW'(mul_a) * PW'(mul_b);

   always_ff @(posedge clock) begin
      if (ctl.mul1) p_ff <= prod;
      if (ctl.mul2) q_ff <= prod;
      if (ctl.mul3) d_ff <= prod;
   end

   // Signed-magnitude sum of the cross products, or the plain product.
   assign q_neg = (cmd_ff == CMD_ADD) ? bn_neg_ff : (!bn_neg_ff && (bn_mag_ff != '0));

   always_comb begin
      nm_in  = p_ff;
      neg_in = an_neg_ff ^ bn_neg_ff;
      if (cmd_ff != CMD_MUL && cmd_ff != CMD_DIV) begin
         if (an_neg_ff == q_neg) begin
            nm_in  = p_ff + q_ff;
            neg_in = an_neg_ff;
         end else if (p_ff >= q_ff) begin
            nm_in  = p_ff - q_ff;
            neg_in = an_neg_ff;
         end else begin
            nm_in  = q_ff - p_ff;
            neg_in = q_neg;
         end
         if (nm_in == '0) neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.comb) begin
         nm_ff  <= nm_in;
         neg_ff <= neg_in;
      end
   end

   // Binary gcd: one shift or one subtraction per cycle, then restore common twos.
   always_comb begin
      gx_in = gx_ff;
      gy_in = gy_ff;
      gk_in = gk_ff;
      if (gx_ff == gy_ff) begin
         gx_in = gx_ff << 1;
         gy_in = gy_ff << 1;
         gk_in = gk_ff - 1'b1;
      end else if (!gx_ff[0] && !gy_ff[0]) begin
         gx_in = gx_ff >> 1;
         gy_in = gy_ff >> 1;
         gk_in = gk_ff + 1'b1;
      end else if (!gx_ff[0]) begin
         gx_in = gx_ff >> 1;
      end else if (!gy_ff[0]) begin
         gy_in = gy_ff >> 1;
      end else if (gx_ff > gy_ff) begin
         gx_in = gx_ff - gy_ff;
      end else begin
         gy_in = gy_ff - gx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.gcd_load) begin
         gx_ff <= nm_ff;
         gy_ff <= d_ff;
         gk_ff <= '0;
      end else if (ctl.gcd_step) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         gk_ff <= gk_in;
      end
   end

   // Restoring division by the gcd, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[PW-1]};
   assign fits  = trial >= {1'b0, gx_ff};

   always_ff @(posedge clock) begin
      if (ctl.div_load) begin
         quo_ff <= ctl.div_den ? d_ff : nm_ff;
         rem_ff <= '0;
         cnt_ff <= CW'(PW);
         if (ctl.div_den) qnum_ff <= quo_ff;
      end else if (ctl.div_step) begin
         rem_ff <= fits ? PW'(trial - {1'b0, gx_ff}) : trial[PW-1:0];
         quo_ff <= {quo_ff[PW-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Result formatting.
   assign num_wide = 64'(qnum_ff);
   assign num_sgn  = neg_ff ? (~num_wide + 64'd1) : num_wide;
   assign den_wide = 64'(quo_ff);

   always_comb begin
      case (cmd_ff)
         CMD_EQ:  cmp_val = (nm_ff == '0);
         CMD_LT:  cmp_val = neg_ff;
         CMD_GT:  cmp_val = !neg_ff && (nm_ff != '0);
         default: cmp_val = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      case (ctl.fin)
         FIN_ZERO: begin
            rsp_res_num  <= '0;
            rsp_res_den  <= '0;
            rsp_cmp_true <= 1'b0;
            rsp_error    <= ERR_NONE;
         end
         FIN_ERR_DEN: begin
            rsp_res_num  <= '0;
            rsp_res_den  <= '0;
            rsp_cmp_true <= 1'b0;
            rsp_error    <= ERR_DEN;
         end
         FIN_ERR_DIV: begin
            rsp_res_num  <= '0;
            rsp_res_den  <= '0;
            rsp_cmp_true <= 1'b0;
            rsp_error    <= ERR_DIV;
         end
         FIN_CMP: begin
            rsp_res_num  <= '0;
            rsp_res_den  <= '0;
            rsp_cmp_true <= cmp_val;
            rsp_error    <= ERR_NONE;
         end
         FIN_FRAC0: begin
            rsp_res_num  <= '0;
            rsp_res_den  <= 31'd1;
            rsp_cmp_true <= 1'b0;
            rsp_error    <= ERR_NONE;
         end
         FIN_FRAC: begin
            rsp_res_num  <= num_sgn[32:0];
            rsp_res_den  <= den_wide[30:0];
            rsp_cmp_true <= 1'b0;
            rsp_error    <= ERR_NONE;
         end
         default: begin
         end
      endcase
   end

   // Status back to the controller.
   assign sts.unused   = (cmd_ff == CMD_UNUSED);
   assign sts.bad_den  = (ad_mag_ff == '0) || (bd_mag_ff == '0);
   assign sts.div_zero = (cmd_ff == CMD_DIV) && (bn_mag_ff == '0);
   assign sts.is_cmp   = cmd_ff inside {CMD_EQ, CMD_LT, CMD_GT};
   assign sts.num_zero = (nm_ff == '0);
   assign sts.gcd_done = (gx_ff == gy_ff) && (gk_ff == '0);
   assign sts.div_last = (cnt_ff == CW'(1));

endmodule

[rtl/fau_control.sv]
// Controller: sequences capture, products, gcd and the two divisions.
module fau_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output fau_pkg::ctl_type ctl,
   input  fau_pkg::sts_type sts
);
   import fau_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_CHECK = 13'b0000000000010,
      ST_MUL1  = 13'b0000000000100,
      ST_MUL2  = 13'b0000000001000,
      ST_MUL3  = 13'b0000000010000,
      ST_COMB  = 13'b0000000100000,
      ST_EVAL  = 13'b0000001000000,
      ST_GCD   = 13'b0000010000000,
      ST_DLN   = 13'b0000100000000,
      ST_DVN   = 13'b0001000000000,
      ST_DLD   = 13'b0010000000000,
      ST_DVD   = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.fin  = FIN_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.cap  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.unused) begin
               ctl.fin  = FIN_ZERO;
               state_in = ST_IDLE;
            end else if (sts.bad_den) begin
               ctl.fin  = FIN_ERR_DEN;
               state_in = ST_IDLE;
            end else if (sts.div_zero) begin
               ctl.fin  = FIN_ERR_DIV;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            ctl.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ctl.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            ctl.mul3 = 1'b1;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            ctl.comb = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.is_cmp) begin
               ctl.fin  = FIN_CMP;
               state_in = ST_IDLE;
            end else if (sts.num_zero) begin
               ctl.fin  = FIN_FRAC0;
               state_in = ST_IDLE;
            end else begin
               ctl.gcd_load = 1'b1;
               state_in     = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               state_in = ST_DLN;
            end else begin
               ctl.gcd_step = 1'b1;
            end
         end
         ST_DLN: begin
            ctl.div_load = 1'b1;
            state_in     = ST_DVN;
         end
         ST_DVN: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) state_in = ST_DLD;
         end
         ST_DLD: begin
            ctl.div_load = 1'b1;
            ctl.div_den  = 1'b1;
            state_in     = ST_DVD;
         end
         ST_DVD: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            ctl.fin  = FIN_FRAC;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and result strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (ctl.fin != FIN_NONE);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule
